// ===== src/lps_pkg.sv =====
// Shared constants and types for the LED panel scroll scanner.
`default_nettype none

package lps_pkg;

  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 32;

  // request kinds carried on in_tuser
  localparam int REQ_W = 2;
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 2'd0,
    REQ_LOAD_TOP = 2'd1,
    REQ_LOAD_BOT = 2'd2,
    REQ_NONE     = 2'd3
  } lps_req_t;

  localparam int LOAD_ROW_W  = 3;
  localparam int LOAD_BITS_W = 32;
  localparam int ROW_ADDR_W  = 3;
  localparam int COLUMN_W    = 5;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = REQ_W;
  localparam int OUT_TDATA_W = 16;

  localparam int                  CFG_W     = 6;
  localparam logic [CFG_W-1:0]    CFG_RESET = 6'd30;

  localparam int                  FRAME_W    = 8;
  localparam logic [FRAME_W-1:0]  FRAME_LAST = 8'hFF;

  // store controls, one transfer or one tick at a time
  typedef struct packed {
    logic wr_top;
    logic wr_bot;
    logic shift_all;
    logic restore_all;
  } lps_ctl_t;

endpackage

`default_nettype wire

// ===== src/lps_row_store.sv =====
// Row memories for the saved top image and the bottom image, with per-row scroll offsets.
`default_nettype none

module lps_row_store
  import lps_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lps_ctl_t                    ctl,
  input  wire logic [$clog2(ROWS)-1:0]     wr_row,
  input  wire logic [COLS-1:0]             wr_bits,
  input  wire logic [$clog2(ROWS)-1:0]     rd_row,
  output logic      [COLS-1:0]             rd_top,
  output logic      [COLS-1:0]             rd_bot,
  output logic      [$clog2(COLS+1)-1:0]   rd_ofs
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int OFS_W = $clog2(COLS + 1);
  localparam logic [OFS_W-1:0] OFS_SAT = OFS_W'(COLS);

  logic [COLS-1:0]  top_mem [ROWS];
  logic [COLS-1:0]  bot_mem [ROWS];
  logic [ROWS-1:0]  top_vld_r;
  logic [ROWS-1:0]  bot_vld_r;
  logic [OFS_W-1:0] ofs_r   [ROWS];
  logic [COLS-1:0]  rd_top_r;
  logic [COLS-1:0]  rd_bot_r;
  logic [OFS_W-1:0] rd_ofs_r;

  // the live top row is the saved word shifted left by its offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_vld_r <= '0;
      bot_vld_r <= '0;
      for (int r = 0; r < ROWS; r++) begin
        ofs_r[r] <= '0;
      end
    end else begin
      if (ctl.wr_top) top_vld_r[wr_row] <= 1'b1;
      if (ctl.wr_bot) bot_vld_r[wr_row] <= 1'b1;
      for (int r = 0; r < ROWS; r++) begin
        if (ctl.restore_all) begin
          ofs_r[r] <= '0;
        end else if (ctl.wr_top && (wr_row == ROW_W'(r))) begin
          ofs_r[r] <= '0;
        end else if (ctl.shift_all && (ofs_r[r] != OFS_SAT)) begin
          ofs_r[r] <= ofs_r[r] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_top) top_mem[wr_row] <= wr_bits;
    if (ctl.wr_bot) bot_mem[wr_row] <= wr_bits;
  end

  always_ff @(posedge clk) begin
    rd_top_r <= top_vld_r[rd_row] ? top_mem[rd_row] : '0;
    rd_bot_r <= bot_vld_r[rd_row] ? bot_mem[rd_row] : '0;
    rd_ofs_r <= ofs_r[rd_row];
  end

  assign rd_top = rd_top_r;
  assign rd_bot = rd_bot_r;
  assign rd_ofs = rd_ofs_r;

endmodule

`default_nettype wire

// ===== src/led_panel_scroll_scanner_top.sv =====
// Top level of the LED panel scroll scanner: request decode, frame counting and column shift-out.
//
// Load requests (in_tuser 1 = top row, 2 = bottom row) write one row word. A refresh
// tick (in_tuser 0) reads the current row from the row memories, then sends its columns
// MSB first, one transfer per column, with out_tlast on the final column as the latch
// point; while out_tready is held high the shift-out sends one column per cycle. Every
// 256th tick scrolls the top image left by one column; at the cfg_wr_data-th such scroll
// point the top image instead reverts to its loaded contents. All stores read as zero
// after reset.
`default_nettype none

module led_panel_scroll_scanner_top
  import lps_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // load_row[2:0], load_bits[34:3], zero pad
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // req_type[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // row_address[2:0], column[7:3],
                                                  // top_bit[8], bottom_bit[9], zero pad
  output logic                        out_tlast,  // latch_last
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_W-1:0]       cfg_wr_data
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int OFS_W = $clog2(COLS + 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;
  logic [ROW_W-1:0]     row_sel_r, row_sel_nxt;
  logic [CFG_W-1:0]     shift_cnt_r, shift_cnt_nxt;
  logic [CFG_W-1:0]     cfg_reload_r;
  logic [ROW_W-1:0]     rd_row_r;
  logic [ROW_ADDR_W-1:0] row_addr_r;
  logic [COL_W-1:0]     col_r;
  logic [COLS-1:0]      tw_r;
  logic [COLS-1:0]      bw_r;

  logic                  accept;
  lps_req_t              req;
  logic [LOAD_ROW_W-1:0] load_row;
  logic [LOAD_BITS_W-1:0] load_bits;
  logic                  row_ok;
  logic                  tick;
  logic                  frame_wrap;
  logic [CFG_W-1:0]      shift_cnt_inc;
  lps_ctl_t              ctl;
  logic [COLS-1:0]       rd_top;
  logic [COLS-1:0]       rd_bot;
  logic [OFS_W-1:0]      rd_ofs;
  logic                  out_xfer;

  assign accept    = in_tvalid && in_tready;
  assign req       = lps_req_t'(in_tuser);
  assign load_row  = in_tdata[LOAD_ROW_W-1:0];
  assign load_bits = in_tdata[LOAD_ROW_W +: LOAD_BITS_W];
  assign row_ok    = 32'(load_row) < ROWS;
  assign tick      = accept && (req == REQ_TICK);
  assign frame_wrap    = frame_r == FRAME_LAST;
  assign shift_cnt_inc = shift_cnt_r + 1'b1;

  always_comb begin
    ctl             = '0;
    ctl.wr_top      = accept && (req == REQ_LOAD_TOP) && row_ok;
    ctl.wr_bot      = accept && (req == REQ_LOAD_BOT) && row_ok;
    ctl.shift_all   = tick && frame_wrap;
    ctl.restore_all = tick && frame_wrap && (shift_cnt_inc == cfg_reload_r);
  end

  lps_row_store #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .wr_row  (ROW_W'(load_row)),
    .wr_bits (COLS'(load_bits)),
    .rd_row  (rd_row_r),
    .rd_top  (rd_top),
    .rd_bot  (rd_bot),
    .rd_ofs  (rd_ofs)
  );

  assign out_xfer = out_tvalid && out_tready;

  always_comb begin
    state_nxt     = state_r;
    frame_nxt     = frame_r;
    row_sel_nxt   = row_sel_r;
    shift_cnt_nxt = shift_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (tick) begin
          state_nxt = S_READ;
          frame_nxt = frame_r + 1'b1;
          // row select follows frame_count mod ROWS, restarting when the frame wraps
          if (frame_wrap || (row_sel_r == ROW_LAST)) row_sel_nxt = '0;
          else                                       row_sel_nxt = row_sel_r + 1'b1;
          if (ctl.restore_all)    shift_cnt_nxt = '0;
          else if (ctl.shift_all) shift_cnt_nxt = shift_cnt_inc;
        end
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_SEND;
      S_SEND: begin
        if (out_xfer && (col_r == COL_LAST)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      frame_r      <= '0;
      row_sel_r    <= '0;
      shift_cnt_r  <= '0;
      cfg_reload_r <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      frame_r     <= frame_nxt;
      row_sel_r   <= row_sel_nxt;
      shift_cnt_r <= shift_cnt_nxt;
      if (cfg_wr_en) cfg_reload_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      rd_row_r   <= row_sel_r;
      row_addr_r <= frame_r[ROW_ADDR_W-1:0];
    end
    if (state_r == S_LOAD) begin
      tw_r  <= rd_top << rd_ofs;
      bw_r  <= rd_bot;
      col_r <= '0;
    end else if (out_xfer) begin
      tw_r  <= tw_r << 1;
      bw_r  <= bw_r << 1;
      col_r <= col_r + 1'b1;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = state_r == S_SEND;
  assign out_tlast  = col_r == COL_LAST;
  assign out_tdata  = {6'b0, bw_r[COLS-1], tw_r[COLS-1], COLUMN_W'(col_r), row_addr_r};

endmodule

`default_nettype wire

// ===== src/lps_checker.sv =====
// Port-level checks for the LED panel scroll scanner, bound to the top level.
`default_nettype none

module lps_checker
  import lps_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic                   out_tlast,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // one request in flight: no intake while a row is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while row transfer pending");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output continued past latch column");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[7:3] == $past(out_tdata[7:3]) + 5'd1)
      && (out_tdata[2:0] == $past(out_tdata[2:0])))
    else $error("column sequence broken");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind led_panel_scroll_scanner_top lps_checker u_lps_checker (.*);

`default_nettype wire
